// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker module.
// Expects signals named clk and rst_n (active low) in the using scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ETB_CHECK_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ETB_CHECK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/etb_pkg.sv =====
// Shared types and constants for the elimination tree builder.
// No dependencies; imported by the interfaces, the top level, the checker and the testbench.
package etb_pkg;

  localparam int unsigned IDX_W          = 10;    // node / column index width
  localparam int unsigned ORD_W          = 11;    // matrix_order register width
  localparam int unsigned EPOCH_W        = 8;     // table generation tag width
  localparam int unsigned MAX_ORDER_DFLT = 1024;

  localparam logic [ORD_W-1:0]   ORDER_RESET = ORD_W'(1024);
  localparam logic [EPOCH_W-1:0] EPOCH_SWEPT = '0;            // tag written by a sweep
  localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);
  localparam logic [EPOCH_W-1:0] EPOCH_LAST  = '1;

  typedef enum logic [2:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_START,
    ST_WALK,
    ST_FIN
  } etb_state_t;

endpackage

// ===== rtl/etb_if.sv =====
// Valid/ready channel interfaces for the elimination tree builder.
// Depends on etb_pkg for the field widths.
interface etb_in_if;
  import etb_pkg::*;
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] row_index;
  logic [IDX_W-1:0] col_index;
  logic             first_of_matrix;
  modport source (output valid, output row_index, output col_index,
                  output first_of_matrix, input ready);
  modport sink   (input valid, input row_index, input col_index,
                  input first_of_matrix, output ready);
endinterface

interface etb_out_if;
  import etb_pkg::*;
  logic             valid;
  logic             ready;
  logic             parent_found;
  logic [IDX_W-1:0] child_node;
  logic [IDX_W-1:0] parent_node;
  logic             index_error;
  modport source (output valid, output parent_found, output child_node,
                  output parent_node, output index_error, input ready);
  modport sink   (input valid, input parent_found, input child_node,
                  input parent_node, input index_error, output ready);
endinterface

interface etb_cfg_if;
  import etb_pkg::*;
  logic             valid;
  logic             ready;
  logic [ORD_W-1:0] matrix_order;
  modport source (output valid, output matrix_order, input ready);
  modport sink   (input valid, input matrix_order, output ready);
endinterface

// ===== rtl/elimination_tree_builder.sv =====
// Elimination tree builder: one result per nonzero, ancestor walk with path compression.
// An accepted item goes to ST_START, then ST_WALK while the walk runs (skipped for errors
// and diagonal/lower entries), then ST_FIN; no item is taken until the result is loaded.
// Walk speed is one step per cycle, set by the registered read of the ancestor memory.
// Reset (rst_n low, synchronous) starts a sweep that writes every ancestor memory entry;
// the same sweep runs on every 255th first_of_matrix item, before that item is started.
module elimination_tree_builder #(
  parameter int unsigned MAX_ORDER = etb_pkg::MAX_ORDER_DFLT
) (
  input logic        clk,
  input logic        rst_n,
  etb_in_if.sink     in_ch,
  etb_out_if.source  out_ch,
  etb_cfg_if.sink    cfg_ch
);
  import etb_pkg::*;

  localparam int unsigned AW  = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
  localparam int unsigned OW  = $clog2(MAX_ORDER + 1);
  localparam int unsigned CW  = (OW > ORD_W) ? OW : ORD_W;
  localparam int unsigned MW  = EPOCH_W + IDX_W;
  localparam logic [AW-1:0] SWEEP_LAST = AW'(MAX_ORDER - 1);

  // ancestor memory: {epoch tag, ancestor}; tag != current epoch means no ancestor
  logic [MW-1:0] anc_mem [MAX_ORDER];
  logic [MW-1:0] rdata_r;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [MW-1:0] mem_wdata;
  logic [AW-1:0] mem_raddr;

  etb_state_t       state_r, state_nxt;
  logic             pend_r;
  logic [EPOCH_W-1:0] epoch_r;
  logic [AW-1:0]    sw_r;
  logic [ORD_W-1:0] matrix_order_r;
  logic [IDX_W-1:0] row_r, col_r, node_r;

  logic             res_found_r, res_err_r;
  logic [IDX_W-1:0] res_child_r, res_parent_r;

  logic             out_valid_r, out_found_r, out_err_r;
  logic [IDX_W-1:0] out_child_r, out_parent_r;

  logic             in_fire, out_free, out_load, sweep_last, need_sweep;
  logic [CW-1:0]    order_eff;
  logic             start_err, start_skip;
  logic [EPOCH_W-1:0] ent_ep;
  logic [IDX_W-1:0] ent_val;
  logic             ent_none, ent_stop;

  assign in_fire    = in_ch.valid && in_ch.ready;
  assign out_free   = !out_valid_r || out_ch.ready;
  assign sweep_last = (sw_r == SWEEP_LAST);
  assign need_sweep = in_ch.first_of_matrix && (epoch_r == EPOCH_LAST);

  assign order_eff  = (CW'(matrix_order_r) > CW'(MAX_ORDER)) ? CW'(MAX_ORDER)
                                                            : CW'(matrix_order_r);
  assign start_err  = (CW'(row_r) >= order_eff) || (CW'(col_r) >= order_eff);
  assign start_skip = (row_r >= col_r);

  assign ent_ep   = rdata_r[MW-1:IDX_W];
  assign ent_val  = rdata_r[IDX_W-1:0];
  assign ent_none = (ent_ep != epoch_r);
  assign ent_stop = ent_none || (ent_val >= col_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_SWEEP: if (sweep_last) state_nxt = pend_r ? ST_START : ST_IDLE;
      ST_IDLE:  if (in_fire) state_nxt = need_sweep ? ST_SWEEP : ST_START;
      ST_START: state_nxt = (start_err || start_skip) ? ST_FIN : ST_WALK;
      ST_WALK:  if (ent_stop) state_nxt = ST_FIN;
      ST_FIN:   if (out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // outputs of the state machine
  always_comb begin
    in_ch.ready = 1'b0;
    mem_we      = 1'b0;
    mem_waddr   = sw_r;
    mem_wdata   = {EPOCH_SWEPT, {IDX_W{1'b0}}};
    mem_raddr   = AW'(row_r);
    out_load    = 1'b0;
    unique case (state_r)
      ST_SWEEP: begin
        mem_we = 1'b1;
      end
      ST_IDLE: begin
        in_ch.ready = 1'b1;
      end
      ST_START: begin
        mem_raddr = AW'(row_r);
      end
      ST_WALK: begin
        // compress: point the visited node at the current column
        mem_we    = 1'b1;
        mem_waddr = AW'(node_r);
        mem_wdata = {epoch_r, col_r};
        mem_raddr = AW'(ent_val);
      end
      ST_FIN: begin
        out_load = out_free;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      anc_mem[mem_waddr] <= mem_wdata;
    end
    rdata_r <= anc_mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_SWEEP;
      pend_r         <= 1'b0;
      epoch_r        <= EPOCH_FIRST;
      sw_r           <= '0;
      matrix_order_r <= ORDER_RESET;
      out_valid_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_ch.valid && cfg_ch.ready) begin
        matrix_order_r <= cfg_ch.matrix_order;
      end
      if (state_r == ST_SWEEP) begin
        sw_r <= sw_r + AW'(1);
      end else begin
        sw_r <= '0;
      end
      if (in_fire) begin
        pend_r <= 1'b1;
        if (in_ch.first_of_matrix) begin
          epoch_r <= (epoch_r == EPOCH_LAST) ? EPOCH_FIRST : epoch_r + EPOCH_W'(1);
        end
      end else if (out_load) begin
        pend_r <= 1'b0;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      row_r <= in_ch.row_index;
      col_r <= in_ch.col_index;
    end
    if (state_r == ST_START) begin
      node_r       <= row_r;
      res_found_r  <= 1'b0;
      res_err_r    <= start_err;
      res_child_r  <= '0;
      res_parent_r <= '0;
    end else if (state_r == ST_WALK) begin
      node_r <= ent_val;
      if (ent_stop) begin
        res_found_r  <= ent_none;
        res_err_r    <= 1'b0;
        res_child_r  <= ent_none ? node_r : '0;
        res_parent_r <= ent_none ? col_r : '0;
      end
    end
    if (out_load) begin
      out_found_r  <= res_found_r;
      out_err_r    <= res_err_r;
      out_child_r  <= res_child_r;
      out_parent_r <= res_parent_r;
    end
  end

  assign cfg_ch.ready        = 1'b1;
  assign out_ch.valid        = out_valid_r;
  assign out_ch.parent_found = out_found_r;
  assign out_ch.child_node   = out_child_r;
  assign out_ch.parent_node  = out_parent_r;
  assign out_ch.index_error  = out_err_r;

endmodule

// ===== rtl/etb_checker.sv =====
// Port-level checks for elimination_tree_builder, attached by bind.
// Depends on etb_pkg and assert_macros.svh.
`include "assert_macros.svh"

module etb_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_valid,
  input logic                      in_ready,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic                      parent_found,
  input logic [etb_pkg::IDX_W-1:0] child_node,
  input logic [etb_pkg::IDX_W-1:0] parent_node,
  input logic                      index_error
);
  import etb_pkg::*;

  `ETB_CHECK_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")
  `ETB_CHECK_NEXT(a_one_item, in_valid && in_ready, !in_ready, "second item taken while busy")
  `ETB_CHECK_NOW(a_par_above, out_valid && parent_found, parent_node > child_node, "parent not above child")
  `ETB_CHECK_NOW(a_err_clean, out_valid && index_error, !parent_found && parent_node == '0 && child_node == '0, "error item reported a parent")

endmodule

bind elimination_tree_builder etb_checker u_etb_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .parent_found (out_ch.parent_found),
  .child_node   (out_ch.child_node),
  .parent_node  (out_ch.parent_node),
  .index_error  (out_ch.index_error)
);

// ===== verif/tb_elimination_tree_builder.sv =====
`timescale 1ns / 100ps
// Testbench for elimination_tree_builder: streams upper, diagonal, lower and out-of-range
// nonzeros, predicts each parent link with a private ancestor table and checks every
// result in order. Depends on etb_pkg and the channel interfaces in etb_if.sv.
module tb_elimination_tree_builder;
  import etb_pkg::*;

  localparam int unsigned TABLE_DEPTH = MAX_ORDER_DFLT;
  localparam logic [ORD_W-1:0] NO_ANCESTOR = '1;
  localparam int unsigned MAX_REPORTS = 40;

  typedef struct packed {
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    logic             first;
  } nonzero_t;

  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] child;
    logic [IDX_W-1:0] parent;
    logic             err;
  } link_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  etb_in_if  in_bus ();
  etb_out_if out_bus ();
  etb_cfg_if cfg_bus ();

  elimination_tree_builder uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_bus),
    .out_ch (out_bus),
    .cfg_ch (cfg_bus)
  );

  logic [ORD_W-1:0] ancestor_of [TABLE_DEPTH];
  logic [ORD_W-1:0] order_reg;
  nonzero_t         pending_nz [$];
  link_t            expected_links [$];
  nonzero_t         drv_nz;
  int unsigned      queued_cnt;
  int unsigned      accepted_cnt;
  int unsigned      mismatch_cnt;
  int unsigned      src_idle_pct;
  int unsigned      sink_stall_pct;

  always #4 clk = ~clk;

  function automatic void clear_ancestors();
    foreach (ancestor_of[k]) ancestor_of[k] = NO_ANCESTOR;
  endfunction

  // Walk up from the row, pointing every visited node at the column.
  function automatic link_t link_for_nonzero(nonzero_t nz);
    link_t            lk;
    int unsigned      lim;
    int unsigned      node;
    logic [ORD_W-1:0] nxt;
    lk = '0;
    if (nz.first) begin
      clear_ancestors();
    end
    lim = (order_reg > TABLE_DEPTH) ? TABLE_DEPTH : order_reg;
    if (nz.row >= lim || nz.col >= lim) begin
      lk.err = 1'b1;
      return lk;
    end
    node = nz.row;
    while (node < nz.col) begin
      nxt = ancestor_of[node];
      ancestor_of[node] = ORD_W'(nz.col);
      if (nxt == NO_ANCESTOR) begin
        lk.found  = 1'b1;
        lk.child  = IDX_W'(node);
        lk.parent = nz.col;
        break;
      end
      node = nxt;
    end
    return lk;
  endfunction

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    mismatch_cnt++;
    if (mismatch_cnt <= MAX_REPORTS) begin
      $display("[%0t] mismatch %s: got %0d, expected %0d", $time, what, got, want);
    end
  endtask

  // Input driver: predict on each transfer, then present the next nonzero.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_bus.valid <= 1'b0;
    end else begin
      if (in_bus.valid && in_bus.ready) begin
        expected_links.insert(expected_links.size(), link_for_nonzero(drv_nz));
        accepted_cnt++;
      end
      if (!in_bus.valid || in_bus.ready) begin
        if (pending_nz.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
          drv_nz = pending_nz.pop_front();
          in_bus.valid           <= 1'b1;
          in_bus.row_index       <= drv_nz.row;
          in_bus.col_index       <= drv_nz.col;
          in_bus.first_of_matrix <= drv_nz.first;
        end else begin
          in_bus.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor with random backpressure.
  always @(posedge clk) begin
    link_t want;
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        if (expected_links.size() == 0) begin
          report_mismatch("result with nothing pending", 1, 0);
        end else begin
          want = expected_links.pop_front();
          if (out_bus.parent_found !== want.found)
            report_mismatch("parent_found", out_bus.parent_found, want.found);
          if (out_bus.child_node !== want.child)
            report_mismatch("child_node", out_bus.child_node, want.child);
          if (out_bus.parent_node !== want.parent)
            report_mismatch("parent_node", out_bus.parent_node, want.parent);
          if (out_bus.index_error !== want.err)
            report_mismatch("index_error", out_bus.index_error, want.err);
        end
      end
      out_bus.ready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  task automatic push_nz(int unsigned r, int unsigned c, bit f);
    nonzero_t nz;
    nz.row   = IDX_W'(r);
    nz.col   = IDX_W'(c);
    nz.first = f;
    pending_nz.insert(pending_nz.size(), nz);
    queued_cnt++;
  endtask

  // Wait until every queued nonzero is taken and answered; return on an edge.
  task automatic drain();
    while (accepted_cnt != queued_cnt || expected_links.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  task automatic write_order(logic [ORD_W-1:0] value);
    cfg_bus.matrix_order <= value;
    cfg_bus.valid        <= 1'b1;
    do @(posedge clk); while (!cfg_bus.ready);
    cfg_bus.valid <= 1'b0;
    order_reg = value;
  endtask

  task automatic start_phase(logic [ORD_W-1:0] value, int unsigned src, int unsigned snk);
    drain();
    write_order(value);
    src_idle_pct   = src;
    sink_stall_pct = snk;
  endtask

  // Column-major upper triangle of an n x n matrix; big orders get sparse columns.
  task automatic push_matrix(int unsigned n);
    int unsigned c;
    int unsigned step;
    int unsigned rows;
    int unsigned r;
    bit          first;
    first = 1'b1;
    step  = (n > 64) ? n / 24 : 1;
    c     = 0;
    while (c < n) begin
      if (c == 0 || $urandom_range(3) == 0) begin
        push_nz(c, c, first);
        first = 1'b0;
      end
      rows = (c == 0) ? 0 : $urandom_range(3);
      for (int k = 0; k < rows; k++) begin
        // Rows just above the diagonal build long chains.
        if ($urandom_range(1))
          r = c - 1 - $urandom_range((c - 1 < 3) ? c - 1 : 3);
        else
          r = $urandom_range(c - 1);
        push_nz(r, c, first);
        first = 1'b0;
      end
      c += $urandom_range(1, step);
    end
  endtask

  task automatic push_noise(int unsigned lim);
    int unsigned c;
    case ($urandom_range(3))
      0: push_nz($urandom_range(1023), $urandom_range(1023), $urandom_range(1) == 1);
      1: begin
        if (lim <= 1023 && $urandom_range(1))
          push_nz(lim, $urandom_range(1023), $urandom_range(1) == 1);
        else if (lim <= 1023)
          push_nz($urandom_range(1023), lim, $urandom_range(1) == 1);
        else
          push_nz($urandom_range(1023), $urandom_range(1023), 1'b1);
      end
      2: begin
        c = $urandom_range(1023);
        push_nz(c + $urandom_range(1023 - c), c, $urandom_range(1) == 1);
      end
      default: begin
        // In-range entry whose column may run backward.
        if (lim >= 2) begin
          c = $urandom_range(1, lim - 1);
          push_nz($urandom_range(c - 1), c, $urandom_range(3) == 0);
        end else begin
          push_nz(0, 0, $urandom_range(1) == 1);
        end
      end
    endcase
  endtask

  task automatic push_random(int unsigned budget);
    int unsigned lim;
    int unsigned n;
    int unsigned pick;
    int unsigned start;
    lim   = (order_reg > TABLE_DEPTH) ? TABLE_DEPTH : order_reg;
    start = queued_cnt;
    while (queued_cnt - start < budget) begin
      if (lim < 2 || $urandom_range(3) == 0) begin
        push_noise(lim);
      end else begin
        pick = $urandom_range(99);
        if (pick < 85)
          n = $urandom_range(2, (lim < 10) ? lim : 10);
        else if (pick < 97)
          n = $urandom_range(2, (lim < 64) ? lim : 64);
        else
          n = $urandom_range(2, lim);
        push_matrix(n);
      end
    end
  endtask

  initial begin
    in_bus.valid           = 1'b0;
    in_bus.row_index       = '0;
    in_bus.col_index       = '0;
    in_bus.first_of_matrix = 1'b0;
    out_bus.ready          = 1'b0;
    cfg_bus.valid          = 1'b0;
    cfg_bus.matrix_order   = '0;
    drv_nz         = '0;
    queued_cnt     = 0;
    accepted_cnt   = 0;
    mismatch_cnt   = 0;
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    order_reg      = ORDER_RESET;
    clear_ancestors();

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: chains, diagonal, lower entry, index extremes, backward column.
    write_order(ORD_W'(1024));
    push_nz(0, 1, 1'b1);
    push_nz(0, 0, 1'b0);
    push_nz(5, 2, 1'b0);
    push_nz(1023, 1023, 1'b0);
    push_nz(0, 1023, 1'b0);
    push_nz(1022, 1023, 1'b0);
    push_nz(1, 1023, 1'b0);
    push_nz(3, 5, 1'b0);
    push_nz(2, 3, 1'b0);
    push_nz(1023, 0, 1'b0);
    push_nz(0, 1023, 1'b1);

    // Out-of-range indices, with a clear on an in-range diagonal item.
    start_phase(ORD_W'(16), 49, 0);
    push_nz(16, 3, 1'b0);
    push_nz(3, 16, 1'b0);
    push_nz(15, 15, 1'b1);
    push_nz(1023, 1023, 1'b0);
    push_nz(14, 15, 1'b0);
    push_nz(2, 15, 1'b0);

    start_phase(ORD_W'(0), 13, 13);
    push_nz(0, 0, 1'b1);
    push_nz(0, 1, 1'b0);
    push_nz(1023, 1023, 1'b1);

    // Order above the table size clamps to it.
    start_phase('1, 0, 49);
    push_nz(1023, 1023, 1'b1);
    push_nz(1022, 1023, 1'b0);
    push_nz(5, 1023, 1'b0);

    start_phase(ORD_W'(1024), 0, 0);
    push_random(180);
    start_phase(ORD_W'(16), 49, 0);
    push_random(120);
    start_phase(ORD_W'(1), 0, 49);
    push_random(50);
    start_phase(ORD_W'(0), 13, 13);
    push_random(30);
    start_phase('1, 13, 13);
    push_random(180);

    // Lower the order mid-matrix: keep going without a clear.
    start_phase(ORD_W'(300), 0, 0);
    repeat (6) begin
      int unsigned c;
      c = $urandom_range(1, 299);
      push_nz($urandom_range(c - 1), c, 1'b0);
    end
    push_random(120);

    start_phase(ORD_W'(64), 49, 0);
    push_random(100);
    start_phase(ORD_W'(1024), 0, 49);
    push_random(150);
    start_phase(ORD_W'(1023), 13, 13);
    push_random(80);

    drain();
    repeat (40) @(posedge clk);
    if (expected_links.size() != 0)
      report_mismatch("results missing at end", 0, expected_links.size());
    if (mismatch_cnt == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #50_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
